// ----- hdl/ljsf_pkg.sv -----
package ljsf_pkg;

    localparam int POS_BITS = 32;
    localparam int SIZE_BITS = POS_BITS + 1;
    localparam int OUT_BITS = 32;

    typedef logic [POS_BITS-1:0]  pos_t;
    typedef logic [SIZE_BITS-1:0] size_t;
    typedef logic [OUT_BITS-1:0]  out_word_t;

    localparam logic [7:0]  MARK_FF = 8'hFF;
    localparam logic [7:0]  MARK_SOI = 8'hD8;
    localparam logic [7:0]  MARK_EOI = 8'hD9;
    localparam logic [15:0] MIN_LENGTH_RESET = 16'd64;
    localparam pos_t        POS_MAX = '1;

    typedef struct packed {
        logic      found;
        out_word_t segment_start;
        out_word_t segment_length;
        logic      overflow;
    } result_t;

    // Clamps a counter-wide value to the 32-bit result fields.
    function automatic out_word_t sat_out(size_t v);
        logic [SIZE_BITS+OUT_BITS-1:0] ext;
        ext = {{OUT_BITS{1'b0}}, v};
        if (|ext[SIZE_BITS+OUT_BITS-1:OUT_BITS])
        begin
            return '1;
        end
        return ext[OUT_BITS-1:0];
    endfunction

endpackage

// ----- hdl/ljsf_scan.sv -----
module ljsf_scan
    import ljsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic [15:0] min_length,
    output result_t     result
);

    pos_t  position_reg, position_next;
    logic  prev_ff_reg, prev_ff_next;
    logic  inside_reg, inside_next;
    pos_t  open_start_reg, open_start_next;
    pos_t  best_offset_reg, best_offset_next;
    size_t best_size_reg, best_size_next;
    logic  overflow_reg, overflow_next;
    size_t seg_len;
    logic  restart;

    assign seg_len = size_t'(position_reg) + size_t'(1) - size_t'(open_start_reg);

    always_comb
    begin
        inside_next = inside_reg;
        open_start_next = open_start_reg;
        best_offset_next = best_offset_reg;
        best_size_next = best_size_reg;
        restart = 1'b0;
        if (!inside_reg)
        begin
            if (prev_ff_reg && data_byte == MARK_SOI)
            begin
                inside_next = 1'b1;
                open_start_next = (position_reg != '0) ? position_reg - pos_t'(1) : '0;
                restart = 1'b1;
            end
        end
        else if (prev_ff_reg && data_byte == MARK_EOI)
        begin
            if (seg_len > best_size_reg)
            begin
                best_size_next = seg_len;
                best_offset_next = open_start_reg;
            end
            inside_next = 1'b0;
            restart = 1'b1;
        end
        prev_ff_next = restart ? 1'b0 : (data_byte == MARK_FF);
        position_next = position_reg;
        overflow_next = overflow_reg;
        if (position_reg == POS_MAX)
        begin
            overflow_next = 1'b1;
        end
        else
        begin
            position_next = position_reg + pos_t'(1);
        end
    end

    always_comb
    begin
        result.found = best_size_next >= size_t'(min_length);
        result.segment_start = sat_out(size_t'(best_offset_next));
        result.segment_length = sat_out(best_size_next);
        result.overflow = overflow_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            prev_ff_reg <= 1'b0;
            inside_reg <= 1'b0;
            open_start_reg <= '0;
            best_offset_reg <= '0;
            best_size_reg <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                position_reg <= '0;
                prev_ff_reg <= 1'b0;
                inside_reg <= 1'b0;
                open_start_reg <= '0;
                best_offset_reg <= '0;
                best_size_reg <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                position_reg <= position_next;
                prev_ff_reg <= prev_ff_next;
                inside_reg <= inside_next;
                open_start_reg <= open_start_next;
                best_offset_reg <= best_offset_next;
                best_size_reg <= best_size_next;
                overflow_reg <= overflow_next;
            end
        end
    end

endmodule

// ----- hdl/largest_jpeg_segment_finder.sv -----
// Scans a byte stream for embedded JPEG segments (FF D8 up to the next FF D9)
// and reports the longest closed one when the stream ends.
// The slave channel takes one stream byte per request, with tlast on the
// final byte of the stream. The master channel gives one result request per
// stream, carrying the start offset and length of the longest segment plus
// the found and overflow flags.
// The block accepts one byte every cycle while s_tready is high; the scan
// state is updated by a single compare-and-subtract stage per accepted byte.
// The result appears on the master channel in the cycle after the last byte
// is accepted and is held in an output register until it is taken. While a
// result waits, the block accepts bytes only if the receiver takes it in
// the same cycle, so a stall on the master side stalls the slave side.
// The minimum length register resets to 64 and is written through cfg_wen and
// cfg_wdata by the user while the block is idle, which it does not enforce.
// Reset clears all stream state and the output register; after each result
// the stream state clears itself and the minimum length is kept.
module largest_jpeg_segment_finder
    import ljsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // segment_start, segment_length
    output logic [1:0]  m_tuser    // found, overflow
);

    logic [15:0] min_length_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     scan_result;
    logic        accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;

    ljsf_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata),
        .is_last    (s_tlast),
        .min_length (min_length_reg),
        .result     (scan_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RESET;
        end
        else if (cfg_wen)
        begin
            min_length_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && s_tlast)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (accept && s_tlast)
        begin
            out_reg <= scan_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {out_reg.segment_length, out_reg.segment_start};
    assign m_tuser = {out_reg.overflow, out_reg.found};

endmodule

// ----- sim/ljsf_scan_checker.sv -----
module ljsf_scan_checker
    import ljsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // segment_start, segment_length
    input  logic [1:0]  m_tuser,   // found, overflow
    output int          mismatches,
    output int          reports_outstanding
);

    logic [15:0] min_len;
    pos_t        byte_pos;
    logic        after_ff;
    logic        in_segment;
    pos_t        seg_open;
    pos_t        top_start;
    size_t       top_len;
    logic        pos_saturated;
    result_t     reports_due[$];

    function automatic out_word_t clamp_word(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? '1 : v[OUT_BITS-1:0];
    endfunction

    task automatic clear_scan();
        byte_pos = '0;
        after_ff = 1'b0;
        in_segment = 1'b0;
        seg_open = '0;
        top_start = '0;
        top_len = '0;
        pos_saturated = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic    marker_taken;
        size_t   seg_len;
        result_t report;
        marker_taken = 1'b0;
        if (!in_segment)
        begin
            if (after_ff && b == MARK_SOI)
            begin
                in_segment = 1'b1;
                seg_open = (byte_pos != '0) ? byte_pos - 1'b1 : '0;
                marker_taken = 1'b1;
            end
        end
        else if (after_ff && b == MARK_EOI)
        begin
            seg_len = size_t'(byte_pos) + 1'b1 - size_t'(seg_open);
            // A later segment replaces the best one only when strictly longer.
            if (seg_len > top_len)
            begin
                top_len = seg_len;
                top_start = seg_open;
            end
            in_segment = 1'b0;
            marker_taken = 1'b1;
        end
        after_ff = marker_taken ? 1'b0 : (b == MARK_FF);
        if (last)
        begin
            report.found = (top_len >= min_len);
            report.segment_start = clamp_word(64'(top_start));
            report.segment_length = clamp_word(64'(top_len));
            report.overflow = pos_saturated;
            reports_due.push_back(report);
            clear_scan();
        end
        else if (byte_pos == POS_MAX)
        begin
            pos_saturated = 1'b1;
        end
        else
        begin
            byte_pos = byte_pos + 1'b1;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            min_len = MIN_LENGTH_RESET;
            clear_scan();
            reports_due.delete();
            mismatches = 0;
            reports_outstanding = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                min_len = cfg_wdata;
            end
            if (m_tvalid && m_tready)
            begin
                if (reports_due.size() == 0)
                begin
                    $display("%0t: unexpected result, start %0d length %0d found %0b ovf %0b",
                             $time, m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]);
                    mismatches++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    compare_field("found", 32'(want.found), 32'(m_tuser[0]));
                    compare_field("segment_start", want.segment_start, m_tdata[31:0]);
                    compare_field("segment_length", want.segment_length, m_tdata[63:32]);
                    compare_field("overflow", 32'(want.overflow), 32'(m_tuser[1]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tdata, s_tlast);
            end
            reports_outstanding = reports_due.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
module tb
    import ljsf_pkg::*;
();

    localparam int RX_HOLD_CYCLES = 400;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int BYTE_GOAL = 1100;
    localparam int STREAM_GOAL = 20;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    int          mismatches;
    int          reports_outstanding;
    int          rx_holds_asked;
    int          rx_holds_done;
    logic        rx_holding;
    logic        no_idle;
    logic [7:0]  stream_q[$];
    int          bytes_sent;
    int          streams_sent;
    int          settings_used;

    largest_jpeg_segment_finder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    ljsf_scan_checker i_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wen             (cfg_wen),
        .cfg_wdata           (cfg_wdata),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tlast             (s_tlast),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .mismatches          (mismatches),
        .reports_outstanding (reports_outstanding)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 90);
    endfunction

    // Markers are favored so that marker pairs also form inside random content.
    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return MARK_FF;
        end
        if (r == 1)
        begin
            return MARK_SOI;
        end
        if (r == 2)
        begin
            return MARK_EOI;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
        begin
            push_byte(stream_q[i], i == stream_q.size() - 1);
        end
        streams_sent++;
    endtask

    task automatic build_random_stream();
        int kind;
        int drop;
        int n;
        stream_q.delete();
        repeat ($urandom_range(1, 4))
        begin
            kind = $urandom_range(0, 9);
            if (kind < 2)
            begin
                repeat ($urandom_range(0, 6)) stream_q.push_back(noise_byte());
            end
            else
            begin
                // A broken segment lacks either its start or its end marker.
                drop = (kind == 9) ? $urandom_range(0, 1) : 2;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 130)
                                                : $urandom_range(0, 20);
                if (drop != 0)
                begin
                    stream_q.push_back(MARK_FF);
                    stream_q.push_back(MARK_SOI);
                end
                repeat (n) stream_q.push_back(noise_byte());
                if (drop != 1)
                begin
                    stream_q.push_back(MARK_FF);
                    stream_q.push_back(MARK_EOI);
                end
            end
        end
        if (stream_q.size() == 0)
        begin
            stream_q.push_back(noise_byte());
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        @(negedge clk);
        while (reports_outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_min_length(input logic [15:0] v);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        m_tready = 1'b0;
        rx_holding = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_holds_asked != rx_holds_done)
            begin
                m_tready <= 1'b0;
                rx_holding = 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_holding = 1'b0;
                rx_holds_done++;
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
                if (!no_idle || $urandom_range(0, 1) == 0)
                begin
                    int gap;
                    gap = pick_gap();
                    if (gap > 0)
                    begin
                        m_tready <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("Timed out with %0d results still outstanding.", reports_outstanding);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int          phase;
        logic [15:0] min_value;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        no_idle = 1'b0;
        rx_holds_asked = 0;
        rx_holds_done = 0;
        bytes_sent = 0;
        streams_sent = 0;
        settings_used = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The segment closes on the last byte itself.
        stream_q = '{8'hFF, 8'hD8, 8'hFF, 8'hD9};
        send_stream();
        // A second start marker inside an open segment is ignored.
        stream_q = '{8'h00, 8'hFF, 8'hD8, 8'hFF, 8'hD8, 8'hFF, 8'hD9};
        send_stream();
        // A doubled FF before the start marker, then a stray end byte.
        stream_q = '{8'hFF, 8'hFF, 8'hD8, 8'hD9, 8'hFF, 8'hD9};
        send_stream();
        // A lone end marker, then a segment left open at the end.
        stream_q = '{8'hD9, 8'hFF, 8'hD9, 8'hFF, 8'hD8, 8'hA5};
        send_stream();
        // With a zero minimum a stream with no segment still reports found.
        settle();
        set_min_length(16'd0);
        stream_q = '{8'h5A};
        send_stream();

        phase = 0;
        while (bytes_sent < BYTE_GOAL || streams_sent < STREAM_GOAL)
        begin
            settle();
            case (phase)
                0: min_value = 16'hFFFF;
                1: min_value = 16'd0;
                2: min_value = 16'd1;
                3: min_value = 16'd12;
                4: min_value = MIN_LENGTH_RESET;
                default:
                    min_value = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                            : 16'($urandom_range(0, 80));
            endcase
            set_min_length(min_value);
            no_idle = (phase == 2) || ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                rx_holds_asked++;
                wait (rx_holding === 1'b1);
            end
            repeat (6)
            begin
                build_random_stream();
                send_stream();
            end
            phase++;
        end
        settle();
        repeat (10) @(posedge clk);

        $display("Scanned %0d bytes in %0d streams under %0d minimum-length settings.",
                 bytes_sent, streams_sent, settings_used);
        $display("Marker edge cases, bursts without gaps and a %0d-cycle result stall ran.",
                 RX_HOLD_CYCLES);
        if (mismatches == 0 && reports_outstanding == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
